/* rtl/core/mpool_pkg.sv */
`timescale 1ns / 1ps

package mpool_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_POOL_W   = 4;
  localparam int CFG_STRIDE_W = 4;
  localparam int CFG_DIM_W    = 11;

  // pooled and argmax coordinates on the result channel
  localparam int OUT_W     = 10;
  localparam int ROW_W     = 10;
  localparam int ROW_LIMIT = 1024;

  localparam logic [CFG_POOL_W-1:0]   POOL_RESET   = 4'd2;
  localparam logic [CFG_STRIDE_W-1:0] STRIDE_RESET = 4'd2;
  localparam logic [CFG_DIM_W-1:0]    HEIGHT_RESET = 11'd32;
  localparam logic [CFG_DIM_W-1:0]    WIDTH_RESET  = 11'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIDE,
    REG_STRIDE,
    REG_PLANE_HEIGHT,
    REG_PLANE_WIDTH
  } cfg_reg_t;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
  } mpool_arg_t;

endpackage

/* rtl/core/mpool_line_store.sv */
`timescale 1ns / 1ps

module mpool_line_store #(
  parameter int SLOTS      = 8,
  parameter int COLS       = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_slot,
  input  logic [$clog2(COLS)-1:0]             wr_col,
  input  logic [DATA_WIDTH-1:0]               wr_data,
  input  logic                                rd_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  input  logic [$clog2(COLS)-1:0]             rd_col,
  output logic [DATA_WIDTH-1:0]               rd_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(COLS);
  localparam int AW = SW + CW;

  logic [DATA_WIDTH-1:0] mem [0:(1 << AW)-1];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_slot, wr_col}] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[{rd_slot, rd_col}];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/mpool_scan.sv */
`timescale 1ns / 1ps

module mpool_scan import mpool_pkg::*; #(
  parameter int MAX_POOL   = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CFG_POOL_W-1:0] job_pool,
  input  logic [((MAX_POOL > 1) ? $clog2(MAX_POOL) : 1)-1:0] job_slot,
  input  logic [ROW_W-1:0]      job_row,
  input  logic [$clog2(MAX_WIDTH)-1:0] job_col,
  output logic                  rd_en,
  output logic [((MAX_POOL > 1) ? $clog2(MAX_POOL) : 1)-1:0] rd_slot,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic [DATA_WIDTH-1:0] rd_data,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] best_value,
  output mpool_arg_t            best_arg
);

  localparam int SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int CW = $clog2(MAX_WIDTH);

  typedef enum logic {SC_IDLE, SC_RUN} scan_state_t;

  scan_state_t           state_r;
  logic [CFG_POOL_W-1:0] pool_r;
  logic [CFG_POOL_W-1:0] px_r;
  logic [CFG_POOL_W-1:0] py_r;
  logic [SW-1:0]         slot_r;
  logic [ROW_W-1:0]      row_r;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         col0_r;

  // issue stage, lines up with the registered read data
  logic                  iss_vld_r;
  logic                  iss_first_r;
  logic                  iss_last_r;
  logic [ROW_W-1:0]      iss_row_r;
  logic [CW-1:0]         iss_col_r;

  logic                  done_r;
  logic [DATA_WIDTH-1:0] best_r;
  mpool_arg_t            best_arg_r;

  logic                  x_end;
  logic                  y_end;
  logic                  take;

  assign x_end = (px_r == pool_r - 1'b1);
  assign y_end = (py_r == pool_r - 1'b1);
  assign take  = iss_vld_r && (iss_first_r || ($signed(rd_data) > $signed(best_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SC_IDLE;
      iss_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      iss_vld_r <= (state_r == SC_RUN);
      done_r    <= iss_vld_r && iss_last_r;
      iss_first_r <= (px_r == '0) && (py_r == '0);
      iss_last_r  <= x_end && y_end;
      iss_row_r   <= row_r;
      iss_col_r   <= col_r;
      case (state_r)
        SC_IDLE: begin
          if (start) begin
            state_r <= SC_RUN;
            pool_r  <= job_pool;
            px_r    <= '0;
            py_r    <= '0;
            slot_r  <= job_slot;
            row_r   <= job_row;
            col_r   <= job_col;
            col0_r  <= job_col;
          end
        end
        SC_RUN: begin
          if (x_end) begin
            px_r   <= '0;
            py_r   <= py_r + 1'b1;
            col_r  <= col0_r;
            row_r  <= row_r + 1'b1;
            slot_r <= (slot_r == SW'(MAX_POOL - 1)) ? '0 : slot_r + 1'b1;
            if (y_end) begin
              state_r <= SC_IDLE;
            end
          end else begin
            px_r  <= px_r + 1'b1;
            col_r <= col_r + 1'b1;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
      if (take) begin
        best_r         <= rd_data;
        best_arg_r.row <= iss_row_r;
        best_arg_r.col <= OUT_W'(iss_col_r);
      end
    end
  end

  assign rd_en      = (state_r == SC_RUN);
  assign rd_slot    = slot_r;
  assign rd_col     = col_r;
  assign done       = done_r;
  assign best_value = best_r;
  assign best_arg   = best_arg_r;

endmodule

/* rtl/core/max_pool_2d_with_argmax_unit.sv */
`timescale 1ns / 1ps

// 2-D max pooling with argmax over a raster stream of Q8.8 samples.
// Input channel (in_valid/in_ready/in_sample): one beat per sample, planes of
// plane_height x plane_width in raster order, back to back; counters restart
// after the last sample of each plane and after any register write.
// Config channel (cfg_*): index 0 window side, 1 stride, 2 plane_height,
// 3 plane_width; other indexes are dropped. Write only while the block idles.
// Result channel (out_*): one beat for each sample that closes a window on the
// stride grid, carrying the max, its pooled position and the input position
// of the max (first in row-major order on ties); out_last_of_plane marks the
// final window of the plane.
// Window scan: a closing sample starts the scan sequencer, which issues one line
// store read per window entry (P the clamped window side); the registered read
// data is then compared. The block takes no new sample while a scan runs. The
// result register lets the next samples enter while a result waits; a stalled
// receiver only holds the block once a second window finishes.
// Reset (synchronous, rst_n low) restores window 2, stride 2, 32 x 32 planes
// and empties the result register. The line store needs no clearing.
module max_pool_2d_with_argmax_unit import mpool_pkg::*; #(
  parameter int MAX_POOL   = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_pooled_value,
  output logic [OUT_W-1:0]      out_out_row,
  output logic [OUT_W-1:0]      out_out_col,
  output logic [OUT_W-1:0]      out_arg_row,
  output logic [OUT_W-1:0]      out_arg_col,
  output logic                  out_last_of_plane,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
  localparam int TW = WW + 1;
  localparam int RT = CFG_DIM_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_POOL_W-1:0]   pool_r;
  logic [CFG_STRIDE_W-1:0] stride_r;
  logic [CFG_DIM_W-1:0]    height_r;
  logic [CFG_DIM_W-1:0]    width_r;

  logic [ROW_W-1:0]        r_r;
  logic [CW-1:0]           c_r;
  logic [SW-1:0]           slot_r;
  logic [CFG_DIM_W-1:0]    row_tgt_r;
  logic [TW-1:0]           col_tgt_r;
  logic [OUT_W-1:0]        orow_r;
  logic [OUT_W-1:0]        ocol_r;

  logic [OUT_W-1:0]        job_orow_r;
  logic [OUT_W-1:0]        job_ocol_r;
  logic                    job_last_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0]   out_value_r;
  logic [OUT_W-1:0]        out_row_r;
  logic [OUT_W-1:0]        out_col_r;
  mpool_arg_t              out_arg_r;
  logic                    out_last_r;

  logic [CFG_POOL_W-1:0]   p;
  logic [CFG_STRIDE_W-1:0] s;
  logic [CFG_DIM_W-1:0]    h;
  logic [WW-1:0]           w;
  logic [CFG_DIM_W-1:0]    eff_rt;
  logic [TW-1:0]           eff_ct;
  logic [OUT_W-1:0]        eff_or;
  logic [OUT_W-1:0]        eff_oc;
  logic                    row_win;
  logic                    col_win;
  logic                    win;
  logic                    win_last;
  logic                    row_end;
  logic                    plane_end;
  logic [SW:0]             base_sum;
  logic [SW-1:0]           base_slot;
  logic [ROW_W-1:0]        win_r0;
  logic [CW-1:0]           win_c0;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    cfg_hit;
  logic                    load_out;

  logic                    wr_en;
  logic                    rd_en;
  logic [SW-1:0]           rd_slot;
  logic [CW-1:0]           rd_col;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic                    scan_done;
  logic [DATA_WIDTH-1:0]   scan_best;
  mpool_arg_t              scan_arg;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == REG_WINDOW_SIDE || cfg_index == REG_STRIDE ||
                                  cfg_index == REG_PLANE_HEIGHT ||
                                  cfg_index == REG_PLANE_WIDTH);

  always_comb begin
    // clamped configuration
    if (pool_r == '0) begin
      p = CFG_POOL_W'(1);
    end else if ({1'b0, pool_r} > (CFG_POOL_W + 1)'(MAX_POOL)) begin
      p = CFG_POOL_W'(MAX_POOL);
    end else begin
      p = pool_r;
    end
    s = (stride_r == '0) ? CFG_STRIDE_W'(1) : stride_r;
    if (height_r == '0) begin
      h = CFG_DIM_W'(1);
    end else if (height_r > CFG_DIM_W'(ROW_LIMIT)) begin
      h = CFG_DIM_W'(ROW_LIMIT);
    end else begin
      h = height_r;
    end
    if (width_r == '0) begin
      w = WW'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_r);
    end

    // next window row / column on the stride grid, tracked without a divider
    eff_rt  = (r_r == '0) ? CFG_DIM_W'(p - 1'b1) : row_tgt_r;
    eff_ct  = (c_r == '0) ? TW'(p - 1'b1) : col_tgt_r;
    eff_or  = (r_r == '0) ? '0 : orow_r;
    eff_oc  = (c_r == '0) ? '0 : ocol_r;
    row_win = (CFG_DIM_W'(r_r) == eff_rt);
    col_win = (TW'(c_r) == eff_ct);
    win     = row_win && col_win;
    // last window when the next one along both axes would not fit
    win_last = ((RT'(eff_rt) + RT'(s)) >= RT'(h)) &&
               (((TW + 1)'(eff_ct) + (TW + 1)'(s)) >= (TW + 1)'(w));

    row_end   = ((WW'(c_r) + 1'b1) == w);
    plane_end = row_end && ((CFG_DIM_W'(r_r) + 1'b1) == h);

    base_sum  = (SW + 1)'(slot_r) + (SW + 1)'(MAX_POOL) - (SW + 1)'(p - 1'b1);
    base_slot = (base_sum >= (SW + 1)'(MAX_POOL)) ?
                SW'(base_sum - (SW + 1)'(MAX_POOL)) : SW'(base_sum);
    win_r0    = r_r - ROW_W'(p - 1'b1);
    win_c0    = CW'(TW'(c_r) - TW'(p - 1'b1));
  end

  always_comb begin
    load_out = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && win) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (!out_valid_r || out_ready) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pool_r      <= POOL_RESET;
      stride_r    <= STRIDE_RESET;
      height_r    <= HEIGHT_RESET;
      width_r     <= WIDTH_RESET;
      r_r         <= '0;
      c_r         <= '0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          REG_WINDOW_SIDE:  pool_r   <= cfg_data[CFG_POOL_W-1:0];
          REG_STRIDE:       stride_r <= cfg_data[CFG_STRIDE_W-1:0];
          REG_PLANE_HEIGHT: height_r <= cfg_data;
          REG_PLANE_WIDTH:  width_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        r_r    <= '0;
        c_r    <= '0;
        slot_r <= '0;
      end else if (in_fire) begin
        col_tgt_r <= col_win ? TW'(eff_ct + TW'(s)) : eff_ct;
        ocol_r    <= eff_oc + OUT_W'(col_win);
        if (row_end) begin
          c_r       <= '0;
          row_tgt_r <= row_win ? CFG_DIM_W'(eff_rt + CFG_DIM_W'(s)) : eff_rt;
          orow_r    <= eff_or + OUT_W'(row_win);
          if (plane_end) begin
            r_r    <= '0;
            slot_r <= '0;
          end else begin
            r_r    <= r_r + 1'b1;
            slot_r <= (slot_r == SW'(MAX_POOL - 1)) ? '0 : slot_r + 1'b1;
          end
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
      if (in_fire && win) begin
        job_orow_r <= eff_or;
        job_ocol_r <= eff_oc;
        job_last_r <= win_last;
      end
      if (load_out) begin
        out_value_r <= scan_best;
        out_row_r   <= job_orow_r;
        out_col_r   <= job_ocol_r;
        out_arg_r   <= scan_arg;
        out_last_r  <= job_last_r;
      end
    end
  end

  assign wr_en = in_fire;

  mpool_line_store #(
    .SLOTS      (MAX_POOL),
    .COLS       (MAX_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_slot (slot_r),
    .wr_col  (c_r),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_slot (rd_slot),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  mpool_scan #(
    .MAX_POOL   (MAX_POOL),
    .MAX_WIDTH  (MAX_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire && win),
    .job_pool   (p),
    .job_slot   (base_slot),
    .job_row    (win_r0),
    .job_col    (win_c0),
    .rd_en      (rd_en),
    .rd_slot    (rd_slot),
    .rd_col     (rd_col),
    .rd_data    (rd_data),
    .done       (scan_done),
    .best_value (scan_best),
    .best_arg   (scan_arg)
  );

  assign out_valid         = out_valid_r;
  assign out_pooled_value  = out_value_r;
  assign out_out_row       = out_row_r;
  assign out_out_col       = out_col_r;
  assign out_arg_row       = out_arg_r.row;
  assign out_arg_col       = out_arg_r.col;
  assign out_last_of_plane = out_last_r;

`ifndef SYNTHESIS
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (state_r == ST_SCAN))
    else $error("scan finished outside of a window job");

  a_win_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && win) |=> (state_r == ST_SCAN))
    else $error("closing sample did not start a window scan");

  a_hold_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("holding a result with an empty output register");

  a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(c_r) < w)
    else $error("column counter ran past the plane width");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mpool_pkg::*;

  localparam int unsigned POOL_CAP      = 8;
  localparam int unsigned WIDTH_CAP     = 1024;
  localparam int unsigned STRIDE_CAP    = 15;
  localparam int unsigned ITEM_GOAL     = 1350;
  // worst window scan is the one over an 8x8 window
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_PLANE_WIDTH) + 1'b1;

  typedef struct packed {
    logic [15:0]      value;
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic [OUT_W-1:0] arg_row;
    logic [OUT_W-1:0] arg_col;
    logic             plane_end;
  } pooled_beat_t;

  function automatic int unsigned bounded(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  class pool_scoreboard;
    logic [CFG_POOL_W-1:0]   pool_reg;
    logic [CFG_STRIDE_W-1:0] stride_reg;
    logic [CFG_DIM_W-1:0]    height_reg;
    logic [CFG_DIM_W-1:0]    width_reg;
    logic signed [15:0]      lines [POOL_CAP*WIDTH_CAP];
    int unsigned             row_pos;
    int unsigned             col_pos;
    pooled_beat_t            due [$];
    int unsigned             noted;
    int unsigned             results;
    int unsigned             errors;

    function new();
      pool_reg   = POOL_RESET;
      stride_reg = STRIDE_RESET;
      height_reg = HEIGHT_RESET;
      width_reg  = WIDTH_RESET;
      row_pos = 0;
      col_pos = 0;
      noted = 0;
      results = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_SIDE:  pool_reg   = data[CFG_POOL_W-1:0];
        REG_STRIDE:       stride_reg = data[CFG_STRIDE_W-1:0];
        REG_PLANE_HEIGHT: height_reg = data[CFG_DIM_W-1:0];
        REG_PLANE_WIDTH:  width_reg  = data[CFG_DIM_W-1:0];
        default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    // store the sample, and queue the window it closes, if any
    function void note_sample(logic [15:0] v);
      int unsigned p, s, h, w, r, c, r0, c0;
      logic signed [15:0] best, cand;
      pooled_beat_t beat;
      p = bounded(pool_reg, POOL_CAP);
      s = bounded(stride_reg, STRIDE_CAP);
      h = bounded(height_reg, ROW_LIMIT);
      w = bounded(width_reg, WIDTH_CAP);
      noted++;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      lines[(r % POOL_CAP) * WIDTH_CAP + c] = v;
      if (r + 1 >= p && c + 1 >= p && (r + 1 - p) % s == 0 && (c + 1 - p) % s == 0) begin
        r0 = r + 1 - p;
        c0 = c + 1 - p;
        best = lines[(r0 % POOL_CAP) * WIDTH_CAP + c0];
        beat.arg_row = OUT_W'(r0);
        beat.arg_col = OUT_W'(c0);
        // strict compare: ties keep the earliest sample in raster order
        for (int y = r0; y < r0 + p; y++) begin
          for (int x = c0; x < c0 + p; x++) begin
            cand = lines[(y % POOL_CAP) * WIDTH_CAP + x];
            if (cand > best) begin
              best = cand;
              beat.arg_row = OUT_W'(y);
              beat.arg_col = OUT_W'(x);
            end
          end
        end
        beat.value     = best;
        beat.out_row   = OUT_W'(r0 / s);
        beat.out_col   = OUT_W'(c0 / s);
        beat.plane_end = (r0 / s == (h - p) / s) && (c0 / s == (w - p) / s);
        due.push_back(beat);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(pooled_beat_t got);
      pooled_beat_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: beat with none expected: value expected none, got %0d", $time,
                   $signed(got.value));
        return;
      end
      want = due.pop_front();
      results++;
      compare("pooled_value", $signed(want.value), $signed(got.value));
      compare("out_row", want.out_row, got.out_row);
      compare("out_col", want.out_col, got.out_col);
      compare("arg_row", want.arg_row, got.arg_row);
      compare("arg_col", want.arg_col, got.arg_col);
      compare("last_of_plane", want.plane_end, got.plane_end);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [15:0]           in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           out_pooled_value;
  logic [OUT_W-1:0]      out_out_row;
  logic [OUT_W-1:0]      out_out_col;
  logic [OUT_W-1:0]      out_arg_row;
  logic [OUT_W-1:0]      out_arg_col;
  logic                  out_last_of_plane;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit                    steady = 1'b0;
  int unsigned           cycles = 0;
  pool_scoreboard        sb;

  max_pool_2d_with_argmax_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pooled_value  (out_pooled_value),
    .out_out_row       (out_out_row),
    .out_out_col       (out_out_col),
    .out_arg_row       (out_arg_row),
    .out_arg_col       (out_arg_col),
    .out_last_of_plane (out_last_of_plane),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_pooled_value, out_out_row, out_out_col, out_arg_row,
                       out_arg_col, out_last_of_plane});
    out_ready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      1, 2:    return 16'($urandom_range(4)) - 16'd2;  // narrow set, lots of ties
      default: return 16'($urandom);
    endcase
  endfunction

  // window side or stride as written, zero and over the window cap now and then
  function automatic int unsigned pick_step();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(15, 9);
    if (r < 6) return $urandom_range(8, 4);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_sample(input logic [15:0] v);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v);
  endtask

  // caller drops cfg_valid after the last beat
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int unsigned p, s, h, w, input bit junk);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idx;
    int unsigned           first;
    vals[REG_WINDOW_SIDE]  = CFG_DATA_W'(p);
    vals[REG_STRIDE]       = CFG_DATA_W'(s);
    vals[REG_PLANE_HEIGHT] = CFG_DATA_W'(h);
    vals[REG_PLANE_WIDTH]  = CFG_DATA_W'(w);
    // bits above the field must be dropped
    if ($urandom_range(3) == 0)
      vals[REG_WINDOW_SIDE][CFG_DATA_W-1:CFG_POOL_W] = (CFG_DATA_W - CFG_POOL_W)'($urandom);
    if ($urandom_range(3) == 0)
      vals[REG_STRIDE][CFG_DATA_W-1:CFG_STRIDE_W] = (CFG_DATA_W - CFG_STRIDE_W)'($urandom);
    first = $urandom_range(3);
    for (int k = 0; k < 4; k++) begin
      idx = CFG_IDX_W'((first + k) % 4);
      write_reg(idx, vals[idx]);
    end
    if (junk)
      write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FIRST_UNUSED)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] corner_set [8];
    int unsigned phase, p_raw, s_raw, pe, h, w, planes, len, count;
    corner_set = '{16'h8000, 16'h7FFF, 16'd5, 16'd5,
                   16'h7FFF, 16'h0000, 16'd5, 16'd5};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // 2x4 plane: full-scale values, a tie across rows, an all-equal window
    configure(2, 2, 2, 4, 1'b0);
    foreach (corner_set[i]) send_sample(corner_set[i]);

    // zero window, stride and height act as one
    settle();
    configure(0, 0, 0, 3, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    // a write to an unused index must not restart the plane
    settle();
    write_reg(REG_FIRST_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_sample(16'h0001);

    // window wider than the plane: never a result
    settle();
    configure(15, 15, 3, 3, 1'b0);
    repeat (9) send_sample(pick_sample());

    phase = 0;
    while (sb.noted < ITEM_GOAL) begin
      // first phase runs with no idling on either side
      steady = (phase == 0);
      settle();
      if (phase == 0) begin
        // over-range width and height, one full clamped row plus a few
        configure(1, 15, 2047, 2047, 1'b0);
        repeat (WIDTH_CAP + 20) send_sample(pick_sample());
      end else begin
        p_raw = pick_step();
        s_raw = pick_step();
        pe = bounded(p_raw, POOL_CAP);
        h = ($urandom_range(9) == 0) ? $urandom_range(pe, 0) : $urandom_range(pe + 5, pe);
        w = ($urandom_range(9) == 0) ? $urandom_range(pe, 0) : $urandom_range(pe + 12, pe);
        configure(p_raw, s_raw, h, w, $urandom_range(4) == 0);
        planes = $urandom_range(3, 1);
        len = bounded(h, ROW_LIMIT) * bounded(w, WIDTH_CAP);
        for (int k = 0; k < planes; k++) begin
          count = len;
          // cut the last plane short now and then
          if (k == planes - 1 && $urandom_range(5) == 0) count = $urandom_range(len - 1);
          repeat (count) send_sample(pick_sample());
          if (phase == 1 || $urandom_range(7) == 0) drain();
        end
      end
      phase++;
    end

    steady = 1'b0;
    settle();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
